/* design/e2q_pkg.sv */
// e2q_pkg: shared widths, constants and the arctangent table for the
// Euler-to-quaternion pipeline. No dependencies.
package e2q_pkg;

  localparam int ANG_W = 31;  // input angle, Q28
  localparam int Z_W = 34;    // CORDIC angle accumulator, Q30
  localparam int XY_W = 34;   // CORDIC vector components, Q30
  localparam int SC_W = 32;   // sine / cosine, Q30
  localparam int Q_W = 33;    // raw quaternion component, Q30
  localparam int MAG_W = 33;  // magnitude, Q30
  localparam int DV_W = 34;   // divided component before saturation
  localparam int OUT_W = 32;  // result component

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int TABLE_LEN = 40;
  localparam int SQRT_STAGES = 32;
  localparam int DIV_QBITS = 31;

  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [Z_W-1:0] atan_q30(input int i);
    logic signed [Z_W-1:0] v;
    begin
      unique case (i)
        0: v = 34'sd843314857;
        1: v = 34'sd497837829;
        2: v = 34'sd263043837;
        3: v = 34'sd133525159;
        4: v = 34'sd67021687;
        5: v = 34'sd33543516;
        6: v = 34'sd16775851;
        7: v = 34'sd8388437;
        8: v = 34'sd4194283;
        9: v = 34'sd2097149;
        default: begin
          if (i >= 10 && i <= 30) v = 34'sd1 <<< (30 - i);
          else v = '0;
        end
      endcase
      return v;
    end
  endfunction

endpackage

/* design/e2q_cordic.sv */
// e2q_cordic: one lane of half-angle fold plus a pipelined rotation-mode
// CORDIC producing sine and cosine in Q30. Depends on e2q_pkg.
module e2q_cordic #(
  parameter int STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic signed [e2q_pkg::ANG_W-1:0]  ang,
  output logic signed [e2q_pkg::SC_W-1:0]   sin_o,
  output logic signed [e2q_pkg::SC_W-1:0]   cos_o
);
  import e2q_pkg::*;

  localparam int N = (STAGES > TABLE_LEN) ? TABLE_LEN : STAGES;

  logic signed [Z_W-1:0]  z_r [0:N];
  logic signed [XY_W-1:0] x_r [0:N];
  logic signed [XY_W-1:0] y_r [0:N];
  logic                   flip_r [0:N];
  logic signed [Z_W-1:0]  h;
  logic signed [SC_W-1:0] sin_r, cos_r;

  // half angle in Q30 is the Q28 input doubled
  assign h = {{2{ang[ANG_W-1]}}, ang, 1'b0};

  // fold into +-pi/2, remember to negate the results
  always_ff @(posedge clk) begin
    x_r[0] <= GAIN_Q30;
    y_r[0] <= '0;
    if (h > HALF_PI_Q30) begin
      z_r[0] <= h - PI_Q30;
      flip_r[0] <= 1'b1;
    end else if (h < -HALF_PI_Q30) begin
      z_r[0] <= h + PI_Q30;
      flip_r[0] <= 1'b1;
    end else begin
      z_r[0] <= h;
      flip_r[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN = atan_q30(i);
    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      if (!z_r[i][Z_W-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - ATAN;
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    sin_r <= flip_r[N] ? SC_W'(-y_r[N]) : SC_W'(y_r[N]);
    cos_r <= flip_r[N] ? SC_W'(-x_r[N]) : SC_W'(x_r[N]);
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

/* design/e2q_isqrt.sv */
// e2q_isqrt: pipelined digit-by-digit integer square root of a 64-bit
// value, one result bit per stage, with a side bus carried alongside.
// Depends on e2q_pkg.
module e2q_isqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                           clk,
  input  logic [63:0]                    n_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic [e2q_pkg::MAG_W-1:0]      root_o,
  output logic [SIDE_W-1:0]              side_o
);
  import e2q_pkg::*;

  logic [63:0]       rem_r  [0:SQRT_STAGES];
  logic [63:0]       root_r [0:SQRT_STAGES];
  logic [SIDE_W-1:0] side_r [0:SQRT_STAGES];

  always_ff @(posedge clk) begin
    rem_r[0] <= n_i;
    root_r[0] <= '0;
    side_r[0] <= side_i;
  end

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] trial;
    assign trial = root_r[i] + BIT;
    always_ff @(posedge clk) begin
      side_r[i+1] <= side_r[i];
      if (rem_r[i] >= trial) begin
        rem_r[i+1] <= rem_r[i] - trial;
        root_r[i+1] <= (root_r[i] >> 1) + BIT;
      end else begin
        rem_r[i+1] <= rem_r[i];
        root_r[i+1] <= root_r[i] >> 1;
      end
    end
  end

  assign root_o = root_r[SQRT_STAGES][MAG_W-1:0];
  assign side_o = side_r[SQRT_STAGES];

endmodule

/* design/e2q_div.sv */
// e2q_div: one lane of rounded, sign-magnitude division of a Q30 component
// by the magnitude, restoring, one quotient bit per stage. Passes the raw
// component when division is off. Depends on e2q_pkg.
module e2q_div (
  input  logic                              clk,
  input  logic signed [e2q_pkg::Q_W-1:0]    q_i,
  input  logic [e2q_pkg::MAG_W-1:0]         mag_i,
  input  logic                              use_i,
  output logic signed [e2q_pkg::DV_W-1:0]   val_o
);
  import e2q_pkg::*;

  logic [Q_W-1:0]       m;
  logic [63:0]          num;

  logic [MAG_W-1:0]     rem_r  [0:DIV_QBITS];
  logic [DIV_QBITS-1:0] low_r  [0:DIV_QBITS];
  logic [DIV_QBITS-1:0] quo_r  [0:DIV_QBITS];
  logic [MAG_W-1:0]     mag_r  [0:DIV_QBITS];
  logic signed [Q_W-1:0] q_r   [0:DIV_QBITS];
  logic                 neg_r  [0:DIV_QBITS];
  logic                 big_r  [0:DIV_QBITS];
  logic                 use_r  [0:DIV_QBITS];
  logic signed [DV_W-1:0] val_r;
  logic signed [DV_W-1:0] res;

  assign m = q_i[Q_W-1] ? Q_W'(-q_i) : Q_W'(q_i);
  assign num = {1'b0, m, 30'd0} + 64'(mag_i >> 1);

  // quotient of 2^31 or more saturates anyway: flag it and skip those bits
  always_ff @(posedge clk) begin
    rem_r[0] <= num[63:31];
    low_r[0] <= num[30:0];
    quo_r[0] <= '0;
    mag_r[0] <= mag_i;
    q_r[0] <= q_i;
    neg_r[0] <= q_i[Q_W-1];
    big_r[0] <= (num[63:31] >= mag_i);
    use_r[0] <= use_i;
  end

  for (genvar i = 0; i < DIV_QBITS; i++) begin : g_stage
    logic [MAG_W:0] part;
    logic           ge;
    assign part = {rem_r[i], low_r[i][DIV_QBITS-1]};
    assign ge = (part >= {1'b0, mag_r[i]});
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? MAG_W'(part - {1'b0, mag_r[i]}) : MAG_W'(part);
      low_r[i+1] <= low_r[i] << 1;
      quo_r[i+1] <= {quo_r[i][DIV_QBITS-2:0], ge};
      mag_r[i+1] <= mag_r[i];
      q_r[i+1] <= q_r[i];
      neg_r[i+1] <= neg_r[i];
      big_r[i+1] <= big_r[i];
      use_r[i+1] <= use_r[i];
    end
  end

  assign res = big_r[DIV_QBITS] ? (DV_W'(1) <<< DIV_QBITS)
                                : DV_W'(quo_r[DIV_QBITS]);

  always_ff @(posedge clk) begin
    if (use_r[DIV_QBITS]) val_r <= neg_r[DIV_QBITS] ? -res : res;
    else val_r <= DV_W'(q_r[DIV_QBITS]);
  end

  assign val_o = val_r;

endmodule

/* design/euler_to_quaternion.sv */
// euler_to_quaternion: top level of the 3-2-1 Euler angle to quaternion
// pipeline. Depends on e2q_pkg, e2q_cordic, e2q_isqrt and e2q_div.
//
// Usage
//   Input: raise start with in_roll, in_pitch, in_yaw (Q28 radians). A
//   request is taken at every rising edge with start high and busy low;
//   busy is held low, so a request can be issued on every cycle.
//   Output: out_valid strobes for one cycle with out_quat_x/y/z/w (Q30,
//   saturated to +-1) and out_renormalized. The receiver cannot stall;
//   results appear in request order, one per request.
//   Throughput: one request per cycle. Depth is set by the CORDIC stages,
//   the 32-stage square root and the 31-bit restoring divider, each one
//   bit or one rotation per stage.
//   Configuration: cfg_we with cfg_data writes renorm_enable; write it only
//   while no request is in flight.
//   Reset: rst_n, synchronous, active low. Clears every valid bit, so no
//   strobe follows reset until a new request, and sets renorm_enable to 1.
//   Data registers are not reset.
module euler_to_quaternion #(
  parameter int CORDIC_STAGES = e2q_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [e2q_pkg::ANG_W-1:0]  in_roll,
  input  logic signed [e2q_pkg::ANG_W-1:0]  in_pitch,
  input  logic signed [e2q_pkg::ANG_W-1:0]  in_yaw,
  output logic                              out_valid,
  output logic signed [e2q_pkg::OUT_W-1:0]  out_quat_x,
  output logic signed [e2q_pkg::OUT_W-1:0]  out_quat_y,
  output logic signed [e2q_pkg::OUT_W-1:0]  out_quat_z,
  output logic signed [e2q_pkg::OUT_W-1:0]  out_quat_w,
  output logic                              out_renormalized,
  input  logic                              cfg_we,
  input  logic                              cfg_data
);
  import e2q_pkg::*;

  localparam int N = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam int CL = N + 2;              // fold, rotations, sign fix
  localparam int SQ_LAT = SQRT_STAGES + 1;
  localparam int DV_LAT = DIV_QBITS + 2;
  localparam int LAT = CL + 5 + SQ_LAT + DV_LAT + 1;
  localparam int SIDE_W = 4 * Q_W + 1;
  localparam logic [37:0] MAG2_HI = 38'd1073956583;
  localparam logic [37:0] MAG2_LO = 38'd1073527086;
  localparam logic [37:0] MAG2_MIN = 38'd10;
  localparam logic signed [DV_W-1:0] SAT_HI = DV_W'(1) <<< 30;

  typedef logic signed [SC_W-1:0] sc_t;
  typedef logic signed [Q_W-1:0] q_t;

  // Q30 product with round-half-up
  function automatic logic signed [37:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    begin
      p = a * b + 68'sd536870912;
      return 38'(p >>> 30);
    end
  endfunction

  function automatic logic signed [OUT_W-1:0] sat(input logic signed [DV_W-1:0] v);
    begin
      if (v > SAT_HI) return OUT_W'(SAT_HI);
      else if (v < -SAT_HI) return OUT_W'(-SAT_HI);
      else return OUT_W'(v);
    end
  endfunction

  logic           en_r;
  logic [LAT-1:0] vld_r;
  logic [DV_LAT-1:0] flag_r;

  sc_t sr, cr, sp, cp, sy, cy;
  sc_t cycp_r, sysp_r, cysp_r, sycp_r, sr1_r, cr1_r;
  sc_t t_r [0:7];
  q_t  q_r [0:3];
  q_t  q4_r [0:3];
  logic [35:0] sq_r [0:3];
  logic        en4_r;
  q_t  q5_r [0:3];
  logic [37:0] s;
  logic [37:0] s_r;
  logic        use5_r;

  logic [SIDE_W-1:0] side_in, side_out;
  logic [MAG_W-1:0]  mag;
  logic              use_div;
  logic signed [DV_W-1:0] dv [0:3];

  logic signed [OUT_W-1:0] qx_r, qy_r, qz_r, qw_r;
  logic                    ren_r;

  // configuration register and valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b1;
      vld_r <= '0;
    end else begin
      if (cfg_we) en_r <= cfg_data;
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  assign busy = 1'b0;

  // sine and cosine of each half angle
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .ang(in_roll), .sin_o(sr), .cos_o(cr));
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .ang(in_pitch), .sin_o(sp), .cos_o(cp));
  e2q_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .ang(in_yaw), .sin_o(sy), .cos_o(cy));

  // pair products of yaw and pitch terms
  always_ff @(posedge clk) begin
    cycp_r <= SC_W'(mul30(34'(cy), 34'(cp)));
    sysp_r <= SC_W'(mul30(34'(sy), 34'(sp)));
    cysp_r <= SC_W'(mul30(34'(cy), 34'(sp)));
    sycp_r <= SC_W'(mul30(34'(sy), 34'(cp)));
    sr1_r <= sr;
    cr1_r <= cr;
  end

  // triple products with the roll terms
  always_ff @(posedge clk) begin
    t_r[0] <= SC_W'(mul30(34'(cycp_r), 34'(sr1_r)));
    t_r[1] <= SC_W'(mul30(34'(sysp_r), 34'(cr1_r)));
    t_r[2] <= SC_W'(mul30(34'(cysp_r), 34'(cr1_r)));
    t_r[3] <= SC_W'(mul30(34'(sycp_r), 34'(sr1_r)));
    t_r[4] <= SC_W'(mul30(34'(sycp_r), 34'(cr1_r)));
    t_r[5] <= SC_W'(mul30(34'(cysp_r), 34'(sr1_r)));
    t_r[6] <= SC_W'(mul30(34'(cycp_r), 34'(cr1_r)));
    t_r[7] <= SC_W'(mul30(34'(sysp_r), 34'(sr1_r)));
  end

  // raw components x, y, z, w
  always_ff @(posedge clk) begin
    q_r[0] <= Q_W'(t_r[0]) - Q_W'(t_r[1]);
    q_r[1] <= Q_W'(t_r[2]) + Q_W'(t_r[3]);
    q_r[2] <= Q_W'(t_r[4]) - Q_W'(t_r[5]);
    q_r[3] <= Q_W'(t_r[6]) + Q_W'(t_r[7]);
  end

  // squares for the magnitude check
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      sq_r[k] <= 36'(mul30(34'(q_r[k]), 34'(q_r[k])));
      q4_r[k] <= q_r[k];
    end
    en4_r <= en_r;
  end

  assign s = 38'(sq_r[0]) + 38'(sq_r[1]) + 38'(sq_r[2]) + 38'(sq_r[3]);

  // decide on renormalization: enabled, off unity but clear of zero
  always_ff @(posedge clk) begin
    s_r <= s;
    use5_r <= en4_r && (s > MAG2_HI || s < MAG2_LO) && (s > MAG2_MIN);
    for (int k = 0; k < 4; k++) q5_r[k] <= q4_r[k];
  end

  assign side_in = {use5_r, q5_r[0], q5_r[1], q5_r[2], q5_r[3]};

  e2q_isqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk(clk), .n_i({s_r[33:0], 30'd0}), .side_i(side_in),
    .root_o(mag), .side_o(side_out));

  assign use_div = side_out[SIDE_W-1] && (mag != '0);

  for (genvar k = 0; k < 4; k++) begin : g_div
    e2q_div u_div (
      .clk(clk),
      .q_i(side_out[(3-k)*Q_W +: Q_W]),
      .mag_i(mag),
      .use_i(use_div),
      .val_o(dv[k]));
  end

  // carry the flag alongside the divider
  always_ff @(posedge clk) begin
    flag_r <= {flag_r[DV_LAT-2:0], use_div};
  end

  // saturate and hold the result for its strobe
  always_ff @(posedge clk) begin
    qx_r <= sat(dv[0]);
    qy_r <= sat(dv[1]);
    qz_r <= sat(dv[2]);
    qw_r <= sat(dv[3]);
    ren_r <= flag_r[DV_LAT-1];
  end

  assign out_valid = vld_r[LAT-1];
  assign out_quat_x = qx_r;
  assign out_quat_y = qy_r;
  assign out_quat_z = qz_r;
  assign out_quat_w = qw_r;
  assign out_renormalized = ren_r;

  // every request gives its strobe at the end of the valid line
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LAT out_valid)
    else $error("request did not produce a strobe at the pipeline latency");

  // no strobe straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("strobe right after reset");

  // x and w components stay within +-1
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_quat_x <= 32'sd1073741824 && out_quat_x >= -32'sd1073741824
                && out_quat_w <= 32'sd1073741824 && out_quat_w >= -32'sd1073741824))
    else $error("component outside saturation range");

endmodule
